// File: design/animated_frame_compositor_core_assert.svh
// Assertion macros for the compositor core.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ANIMATED_FRAME_COMPOSITOR_CORE_ASSERT_SVH
`define ANIMATED_FRAME_COMPOSITOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define AFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AFC_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define AFC_ASSERT(label, prop, msg)
`define AFC_IMPLY(label, ante, cons, msg)
`endif
`endif

// File: design/afc_pkg.sv
package afc_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 20;
    localparam int AREA_W      = 18;
    localparam int DIM_W       = 9;
    localparam int PIX_W       = 32;
    localparam int DIV_NUM_W   = 26;
    localparam int DIV_DEN_W   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_NO_OUT  = 2'd3;

    localparam logic [1:0] DISP_CLEAR   = 2'd1;
    localparam logic [1:0] DISP_RESTORE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_PIX,
        KIND_READ,
        KIND_DONE
    } kind_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_PADDR,
        S_PREAD,
        S_PMUL,
        S_PWRITE,
        S_PCHECK,
        S_SWEEP,
        S_CLEAR,
        S_COMMIT,
        S_RREAD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic init_run;
        logic pix_addr;
        logic pix_read;
        logic pix_mul;
        logic pix_write;
        logic sweep_start;
        logic sweep_run;
        logic clear_start;
        logic clear_run;
        logic frame_commit;
        logic rd_read;
        logic resp_load;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t acc_kind;
        logic  div_done;
        logic  pix_last;
        logic  sweep_done;
        logic  need_clear;
        logic  clear_done;
        logic  init_done;
        logic  out_busy;
    } stat_t;

    // floor(x/255), exact for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    // (by+oy)*cw + bx+ox
    function automatic logic [IDX_W-1:0] canvas_index(input logic [7:0] bx,
                                                      input logic [7:0] by,
                                                      input logic [DIM_W-1:0] ox,
                                                      input logic [DIM_W-1:0] oy,
                                                      input logic [DIM_W-1:0] cw);
        logic [9:0]       row;
        logic [9:0]       col;
        logic [IDX_W-1:0] prod;
        row  = {2'b00, by} + {1'b0, oy};
        col  = {2'b00, bx} + {1'b0, ox};
        prod = IDX_W'(row) * IDX_W'(cw);
        return prod + IDX_W'(col);
    endfunction

endpackage

// File: design/afc_in_if.sv
interface afc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  region_x;
    logic [7:0]  region_y;
    logic [8:0]  region_width;
    logic [8:0]  region_height;
    logic        blend_mode;
    logic [1:0]  dispose_mode;
    logic [15:0] delay_numerator;
    logic [15:0] delay_denominator;
    logic [31:0] pixel_in;
    logic [15:0] read_index;

    modport source (
        output valid, op, region_x, region_y, region_width, region_height,
               blend_mode, dispose_mode, delay_numerator, delay_denominator,
               pixel_in, read_index,
        input  ready
    );
    modport sink (
        input  valid, op, region_x, region_y, region_width, region_height,
               blend_mode, dispose_mode, delay_numerator, delay_denominator,
               pixel_in, read_index,
        output ready
    );
endinterface

// File: design/afc_out_if.sv
interface afc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] delay_ms;
    logic        frame_done;
    logic [15:0] frame_number;
    logic [31:0] pixel_out;

    modport source (
        output valid, status, delay_ms, frame_done, frame_number, pixel_out,
        input  ready
    );
    modport sink (
        input  valid, status, delay_ms, frame_done, frame_number, pixel_out,
        output ready
    );
endinterface

// File: design/afc_div.sv
module afc_div
    import afc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 take;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, num_reg[DIV_NUM_W-1]};
        take      = rem_sh >= {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            rem_next = take ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], take};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = !busy_reg;
    assign quo  = num_reg;

endmodule

// File: design/afc_ctrl.sv
module afc_ctrl
    import afc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_run = 1'b1;
                if (stat.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (stat.acc_kind)
                        KIND_HDR:  state_next = S_DIV;
                        KIND_PIX:  state_next = S_PADDR;
                        KIND_READ: state_next = S_RREAD;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_RESP;
            end
            S_PADDR:
            begin
                cmd.pix_addr = 1'b1;
                state_next   = S_PREAD;
            end
            S_PREAD:
            begin
                cmd.pix_read = 1'b1;
                state_next   = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.pix_mul = 1'b1;
                state_next  = S_PWRITE;
            end
            S_PWRITE:
            begin
                cmd.pix_write = 1'b1;
                state_next    = S_PCHECK;
            end
            S_PCHECK:
            begin
                if (stat.pix_last)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SWEEP;
                end
                else
                    state_next = S_RESP;
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                begin
                    if (stat.need_clear)
                    begin
                        cmd.clear_start = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else
                        state_next = S_COMMIT;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (stat.clear_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.frame_commit = 1'b1;
                state_next       = S_RESP;
            end
            S_RREAD:
            begin
                cmd.rd_read = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_INIT;
        endcase
    end

endmodule

// File: design/afc_dpath.sv
`include "animated_frame_compositor_core_assert.svh"

module afc_dpath
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    afc_in_if.sink                in_ch,
    afc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output stat_t                 stat
);

    // configuration
    logic [DIM_W-1:0] cw_cfg_reg, ch_cfg_reg;
    logic [15:0]      total_reg;
    logic [DIM_W-1:0] cw_eff, ch_eff;

    // architectural state
    logic             have_output_reg, finished_reg, in_frame_reg;
    logic [15:0]      fi_reg;
    logic [DIM_W-1:0] cur_x_reg, cur_y_reg;
    logic [7:0]       hx_reg, hy_reg;
    logic [DIM_W-1:0] hw_reg, hh_reg;
    logic             hblend_reg;
    logic [1:0]       hdisp_reg;

    // item
    kind_t            kind_reg, acc_kind;
    logic [1:0]       st_reg, acc_st;
    logic [15:0]      fnum_reg, acc_fnum;
    logic [PIX_W-1:0] src_reg;
    logic [15:0]      ri_reg;
    logic             done_reg;
    logic             hdr_refuse, hdr_bad, ri_bad;
    logic [AREA_W-1:0] area;

    // pixel path
    logic [IDX_W-1:0]  pidx;
    logic [ADDR_W-1:0] idx_reg;
    logic              idx_ok_reg;
    logic [15:0]       prod_reg [4];
    logic [15:0]       prod_next [4];
    logic [PIX_W-1:0]  blended;
    logic [DIM_W-1:0]  x_inc, y_inc;

    // memories
    logic [PIX_W-1:0]  canvas_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  lo_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  cv_q, lo_q;
    logic              cv_we, cv_re, lo_we, lo_re;
    logic [ADDR_W-1:0] cv_waddr, cv_raddr, lo_raddr;
    logic [PIX_W-1:0]  cv_wdata;
    logic [3:0]        cv_wr_src;

    // sweeps
    logic [CNT_W-1:0]  init_cnt_reg;
    logic [CNT_W-1:0]  sw_cnt_reg;
    logic              sw_pipe_reg, sw_swap_reg, sw_issue;
    logic [ADDR_W-1:0] sw_addr_reg;
    logic [DIM_W-1:0]  cl_x_reg, cl_y_reg;
    logic [IDX_W-1:0]  cidx;
    logic              clr_done, clr_step;

    // delay divider
    logic [DIV_DEN_W-1:0] den_eff;
    logic [DIV_NUM_W-1:0] num_k, quo;
    logic                 div_done, div_start;
    logic [15:0]          delay_sat;

    // output register
    logic             out_valid_reg;
    logic [1:0]       o_status_reg;
    logic [15:0]      o_delay_reg;
    logic             o_done_reg;
    logic [15:0]      o_fnum_reg;
    logic [PIX_W-1:0] o_pix_reg;

    assign cw_eff = (cw_cfg_reg > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cw_cfg_reg;
    assign ch_eff = (ch_cfg_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : ch_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_cfg_reg <= DIM_W'(MAX_WIDTH);
            ch_cfg_reg <= DIM_W'(MAX_HEIGHT);
            total_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cw_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: ch_cfg_reg <= cfg_data[DIM_W-1:0];
                CFG_FRAMES: total_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // item decode against the state seen at acceptance
    assign hdr_refuse = finished_reg || in_frame_reg || (fi_reg >= total_reg);
    assign hdr_bad    = (in_ch.region_width == '0) || (in_ch.region_height == '0)
                     || (({2'b00, in_ch.region_x} + {1'b0, in_ch.region_width})
                         > {1'b0, cw_eff})
                     || (({2'b00, in_ch.region_y} + {1'b0, in_ch.region_height})
                         > {1'b0, ch_eff});
    assign area   = AREA_W'(cw_eff) * AREA_W'(ch_eff);
    assign ri_bad = {2'b00, in_ch.read_index} >= area;

    always_comb
    begin
        acc_kind = KIND_DONE;
        acc_st   = ST_REFUSED;
        acc_fnum = fi_reg;
        unique case (in_ch.op)
            OP_HEADER:
            begin
                if (hdr_refuse)
                    acc_st = ST_REFUSED;
                else if (hdr_bad)
                    acc_st = ST_BAD;
                else
                begin
                    acc_st   = ST_OK;
                    acc_kind = KIND_HDR;
                end
            end
            OP_PIXEL:
            begin
                if (!finished_reg && in_frame_reg)
                begin
                    acc_st   = ST_OK;
                    acc_kind = KIND_PIX;
                end
            end
            OP_READ:
            begin
                if (!have_output_reg)
                begin
                    acc_st   = ST_NO_OUT;
                    acc_fnum = '0;
                end
                else
                begin
                    acc_fnum = fi_reg - 16'd1;
                    if (ri_bad)
                        acc_st = ST_BAD;
                    else
                    begin
                        acc_st   = ST_OK;
                        acc_kind = KIND_READ;
                    end
                end
            end
            default:
                acc_st = ST_REFUSED;
        endcase
    end

    assign den_eff   = (in_ch.delay_denominator == '0) ? DIV_DEN_W'(100)
                                                       : in_ch.delay_denominator;
    assign num_k     = DIV_NUM_W'(in_ch.delay_numerator) * DIV_NUM_W'(1000);
    assign div_start = cmd.accept && (acc_kind == KIND_HDR);
    assign delay_sat = (|quo[DIV_NUM_W-1:16]) ? 16'hFFFF : quo[15:0];

    afc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_k),
        .den   (den_eff),
        .done  (div_done),
        .quo   (quo)
    );

    // pixel address and blend
    assign pidx  = canvas_index(hx_reg, hy_reg, cur_x_reg, cur_y_reg, cw_eff);
    assign x_inc = cur_x_reg + 1'b1;
    assign y_inc = cur_y_reg + 1'b1;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c] = {8'd0, cv_q[8*c +: 8]} * {8'd0, 8'd255 - src_reg[31:24]}
                         + {8'd0, src_reg[8*c +: 8]} * {8'd0, src_reg[31:24]};
            blended[8*c +: 8] = div255(prod_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_addr)
        begin
            idx_reg    <= pidx[ADDR_W-1:0];
            idx_ok_reg <= pidx < IDX_W'(STORE_DEPTH);
        end
        if (cmd.pix_mul)
            prod_reg <= prod_next;
        if (cmd.accept)
        begin
            kind_reg <= acc_kind;
            st_reg   <= acc_st;
            fnum_reg <= acc_fnum;
            src_reg  <= in_ch.pixel_in;
            ri_reg   <= in_ch.read_index;
        end
    end

    // state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_output_reg <= 1'b0;
            finished_reg    <= 1'b0;
            in_frame_reg    <= 1'b0;
            fi_reg          <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            hx_reg          <= '0;
            hy_reg          <= '0;
            hw_reg          <= '0;
            hh_reg          <= '0;
            hblend_reg      <= 1'b0;
            hdisp_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
                done_reg <= 1'b0;
            if (cmd.accept && (acc_kind == KIND_HDR))
            begin
                hx_reg       <= in_ch.region_x;
                hy_reg       <= in_ch.region_y;
                hw_reg       <= in_ch.region_width;
                hh_reg       <= in_ch.region_height;
                hblend_reg   <= in_ch.blend_mode;
                hdisp_reg    <= in_ch.dispose_mode;
                in_frame_reg <= 1'b1;
                cur_x_reg    <= '0;
                cur_y_reg    <= '0;
            end
            if (cmd.pix_write)
            begin
                if (x_inc >= hw_reg)
                begin
                    cur_x_reg <= '0;
                    cur_y_reg <= y_inc;
                    done_reg  <= y_inc >= hh_reg;
                end
                else
                begin
                    cur_x_reg <= x_inc;
                    done_reg  <= cur_y_reg >= hh_reg;
                end
            end
            if (cmd.frame_commit)
            begin
                have_output_reg <= 1'b1;
                in_frame_reg    <= 1'b0;
                fi_reg          <= fi_reg + 16'd1;
                finished_reg    <= finished_reg || ((fi_reg + 16'd1) >= total_reg);
            end
        end
    end

    // reset clear, frame-end sweep and region clear
    assign sw_issue = cmd.sweep_run && !sw_cnt_reg[CNT_W-1];
    assign cidx     = canvas_index(hx_reg, hy_reg, cl_x_reg, cl_y_reg, cw_eff);
    assign clr_done = cl_y_reg >= hh_reg;
    assign clr_step = cmd.clear_run && !clr_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            sw_cnt_reg   <= '0;
            sw_pipe_reg  <= 1'b0;
            sw_swap_reg  <= 1'b0;
            cl_x_reg     <= '0;
            cl_y_reg     <= '0;
        end
        else
        begin
            if (cmd.init_run && !init_cnt_reg[CNT_W-1])
                init_cnt_reg <= init_cnt_reg + 1'b1;
            sw_pipe_reg <= sw_issue;
            if (cmd.sweep_start)
            begin
                sw_cnt_reg  <= '0;
                sw_swap_reg <= (hdisp_reg == DISP_RESTORE) && (fi_reg != '0);
            end
            else if (sw_issue)
                sw_cnt_reg <= sw_cnt_reg + 1'b1;
            if (cmd.clear_start)
            begin
                cl_x_reg <= '0;
                cl_y_reg <= '0;
            end
            else if (clr_step)
            begin
                if ((cl_x_reg + 1'b1) >= hw_reg)
                begin
                    cl_x_reg <= '0;
                    cl_y_reg <= cl_y_reg + 1'b1;
                end
                else
                    cl_x_reg <= cl_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sw_issue)
            sw_addr_reg <= sw_cnt_reg[ADDR_W-1:0];
    end

    // canvas port arbitration
    always_comb
    begin
        cv_wr_src[0] = cmd.init_run && !init_cnt_reg[CNT_W-1];
        cv_wr_src[1] = cmd.pix_write && idx_ok_reg;
        cv_wr_src[2] = sw_pipe_reg && sw_swap_reg;
        cv_wr_src[3] = clr_step && (cidx < IDX_W'(STORE_DEPTH));
        cv_we        = |cv_wr_src;
        cv_waddr     = init_cnt_reg[ADDR_W-1:0];
        cv_wdata     = '0;
        if (cv_wr_src[1])
        begin
            cv_waddr = idx_reg;
            cv_wdata = hblend_reg ? blended : src_reg;
        end
        else if (cv_wr_src[2])
        begin
            cv_waddr = sw_addr_reg;
            cv_wdata = lo_q;
        end
        else if (cv_wr_src[3])
            cv_waddr = cidx[ADDR_W-1:0];
        cv_re    = cmd.pix_read || sw_issue;
        cv_raddr = cmd.pix_read ? idx_reg : sw_cnt_reg[ADDR_W-1:0];
        lo_we    = sw_pipe_reg;
        lo_re    = cmd.rd_read || sw_issue;
        lo_raddr = cmd.rd_read ? ri_reg : sw_cnt_reg[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cv_we)
            canvas_mem[cv_waddr] <= cv_wdata;
        if (cv_re)
            cv_q <= canvas_mem[cv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
            lo_mem[sw_addr_reg] <= cv_q;
        if (lo_re)
            lo_q <= lo_mem[lo_raddr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.resp_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            o_status_reg <= st_reg;
            o_delay_reg  <= (kind_reg == KIND_HDR) ? delay_sat : 16'd0;
            o_done_reg   <= (kind_reg == KIND_PIX) && done_reg;
            o_fnum_reg   <= fnum_reg;
            o_pix_reg    <= (kind_reg == KIND_READ) ? lo_q : '0;
        end
    end

    assign in_ch.ready         = cmd.in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = o_status_reg;
    assign out_ch.delay_ms     = o_delay_reg;
    assign out_ch.frame_done   = o_done_reg;
    assign out_ch.frame_number = o_fnum_reg;
    assign out_ch.pixel_out    = o_pix_reg;

    assign stat.in_valid   = in_ch.valid;
    assign stat.acc_kind   = acc_kind;
    assign stat.div_done   = div_done;
    assign stat.pix_last   = done_reg;
    assign stat.sweep_done = sw_cnt_reg[CNT_W-1] && !sw_pipe_reg;
    assign stat.need_clear = (hdisp_reg == DISP_CLEAR) && !sw_swap_reg;
    assign stat.clear_done = clr_done;
    assign stat.init_done  = init_cnt_reg[CNT_W-1];
    assign stat.out_busy   = out_valid_reg && !out_ch.ready;

    `AFC_ASSERT(a_frame_flags, !(in_frame_reg && finished_reg), "frame open after finish")
    `AFC_ASSERT(a_canvas_one_writer, $onehot0(cv_wr_src), "canvas write port contention")
    `AFC_IMPLY(a_resp_slot_free, cmd.resp_load, !out_valid_reg || out_ch.ready, "result overrun")
    `AFC_IMPLY(a_sweep_exclusive, sw_issue, !cmd.pix_write && !cmd.rd_read, "sweep overlaps item")

endmodule

// File: design/animated_frame_compositor_core.sv
// Channel  | Dir | Transaction payload
// ---------+-----+------------------------------------------------------------
// in_ch    | in  | op, region, blend/dispose mode, delay fraction, pixel, index
// out_ch   | out | status, delay_ms, frame_done, frame_number, pixel_out
// cfg      | in  | cfg_we / cfg_index / cfg_data, no handshake, no read-back
//
// One transaction in flight. A refused or bad item goes straight to its response, an
// accepted header waits for the shift-subtract divider, a read makes one output RAM
// read and a pixel makes a canvas read-modify-write. A frame's last pixel adds a pass
// for the canvas/output copy (or swap on restore), plus a region clear for a clear
// dispose. After reset a clearing pass zeroes the canvas RAM, with in_ch not ready.
// A stalled out_ch holds its result; the next transaction waits only at its own.
module animated_frame_compositor_core
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    afc_in_if.sink                in_ch,
    afc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // controller drives commands, datapath returns status
    cmd_t  cmd;
    stat_t stat;

    afc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath owns both RAMs, the divider and the result register
    afc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
